[rtl/rv32ex_pkg.sv]
// Shared types and constants for the RV32IM execute unit.
package rv32ex_pkg;

   typedef struct packed {
      logic [31:0] instr;
      logic [31:0] pc;
      logic [31:0] rs1_value;
      logic [31:0] rs2_value;
   } req_type;

   typedef struct packed {
      logic [4:0]  rd_index;
      logic        rd_write;
      logic [31:0] rd_value;
      logic [31:0] next_pc;
      logic [1:0]  mem_kind;
      logic [2:0]  mem_bytes;
      logic [31:0] mem_addr;
      logic [31:0] store_data;
      logic [1:0]  status;
   } rsp_type;

   // Operation classes produced by the front end
   localparam logic [3:0] CLS_ILLEGAL = 4'd0;
   localparam logic [3:0] CLS_LUI     = 4'd1;
   localparam logic [3:0] CLS_AUIPC   = 4'd2;
   localparam logic [3:0] CLS_JAL     = 4'd3;
   localparam logic [3:0] CLS_JALR    = 4'd4;
   localparam logic [3:0] CLS_BRANCH  = 4'd5;
   localparam logic [3:0] CLS_LOAD    = 4'd6;
   localparam logic [3:0] CLS_STORE   = 4'd7;
   localparam logic [3:0] CLS_ALU     = 4'd8;
   localparam logic [3:0] CLS_MUL     = 4'd9;
   localparam logic [3:0] CLS_DIV     = 4'd10;
   localparam logic [3:0] CLS_NOP     = 4'd11;
   localparam logic [3:0] CLS_ECALL   = 4'd12;
   localparam logic [3:0] CLS_MRET    = 4'd13;
   localparam logic [3:0] CLS_EBREAK  = 4'd14;
   localparam logic [3:0] CLS_CSR     = 4'd15;

   // ALU operations
   localparam logic [3:0] ALU_ADD  = 4'd0;
   localparam logic [3:0] ALU_SUB  = 4'd1;
   localparam logic [3:0] ALU_SLL  = 4'd2;
   localparam logic [3:0] ALU_SLT  = 4'd3;
   localparam logic [3:0] ALU_SLTU = 4'd4;
   localparam logic [3:0] ALU_XOR  = 4'd5;
   localparam logic [3:0] ALU_SRL  = 4'd6;
   localparam logic [3:0] ALU_SRA  = 4'd7;
   localparam logic [3:0] ALU_OR   = 4'd8;
   localparam logic [3:0] ALU_AND  = 4'd9;

   localparam logic [1:0] MEM_NONE  = 2'd0;
   localparam logic [1:0] MEM_LOADS = 2'd1;
   localparam logic [1:0] MEM_LOADU = 2'd2;
   localparam logic [1:0] MEM_STORE = 2'd3;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_EBREAK  = 2'd1;
   localparam logic [1:0] ST_ILLEGAL = 2'd2;

   localparam logic [11:0] CSR_MSTATUS  = 12'h300;
   localparam logic [11:0] CSR_MTVEC    = 12'h305;
   localparam logic [11:0] CSR_MSCRATCH = 12'h340;
   localparam logic [11:0] CSR_MEPC     = 12'h341;
   localparam logic [11:0] CSR_MCAUSE   = 12'h342;
   localparam logic [31:0] MSTATUS_MPP_MASK = 32'h0000_1800;
   localparam logic [31:0] CAUSE_ECALL_M    = 32'd11;

   // Decoded operation passed from front to back
   typedef struct packed {
      logic [3:0]  cls;
      logic [3:0]  alu_op;
      logic [2:0]  f3;
      logic        use_imm;
      logic [31:0] imm;
      logic [4:0]  rd;
      logic [31:0] instr;
      logic [31:0] pc;
      logic [31:0] a;
      logic [31:0] b;
   } dec_type;

endpackage

[rtl/rv32ex_decode.sv]
// Front end: accepts instructions, decodes class and immediate, holds one in a register.
module rv32ex_decode import rv32ex_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    dec_valid,
   input  logic    dec_ready,
   output dec_type dec_data
);

   logic    valid_ff, valid_in;
   dec_type data_ff, data_in;

   always_comb begin
      logic [31:0] ins;
      logic [6:0]  op;
      logic [2:0]  f3;
      logic [6:0]  f7;
      logic [31:0] sx;
      ins = req_data.instr;
      op  = ins[6:0];
      f3  = ins[14:12];
      f7  = ins[31:25];
      sx  = {32{ins[31]}};
      data_in         = '0;
      data_in.instr   = ins;
      data_in.pc      = req_data.pc;
      data_in.a       = req_data.rs1_value;
      data_in.b       = req_data.rs2_value;
      data_in.rd      = ins[11:7];
      data_in.f3      = f3;
      data_in.cls     = CLS_ILLEGAL;
      data_in.alu_op  = ALU_ADD;
      data_in.use_imm = 1'b0;
      data_in.imm     = {sx[31:12], ins[31:20]};
      unique case (op)
         7'h37: begin data_in.cls = CLS_LUI; data_in.imm = {ins[31:12], 12'd0}; end
         7'h17: begin data_in.cls = CLS_AUIPC; data_in.imm = {ins[31:12], 12'd0}; end
         7'h6F: begin
            data_in.cls = CLS_JAL;
            data_in.imm = {sx[31:20], ins[19:12], ins[20], ins[30:21], 1'b0};
         end
         7'h67: if (f3 == 3'd0) data_in.cls = CLS_JALR;
         7'h63: begin
            data_in.imm = {sx[31:12], ins[7], ins[30:25], ins[11:8], 1'b0};
            if (f3 != 3'd2 && f3 != 3'd3) data_in.cls = CLS_BRANCH;
         end
         7'h03: if (f3 != 3'd3 && f3 != 3'd6 && f3 != 3'd7) data_in.cls = CLS_LOAD;
         7'h23: begin
            data_in.imm = {sx[31:12], ins[31:25], ins[11:7]};
            if (f3 <= 3'd2) data_in.cls = CLS_STORE;
         end
         7'h13: begin
            data_in.use_imm = 1'b1;
            data_in.cls = CLS_ALU;
            case (f3)
               3'd0: data_in.alu_op = ALU_ADD;
               3'd2: data_in.alu_op = ALU_SLT;
               3'd3: data_in.alu_op = ALU_SLTU;
               3'd4: data_in.alu_op = ALU_XOR;
               3'd6: data_in.alu_op = ALU_OR;
               3'd7: data_in.alu_op = ALU_AND;
               3'd1: begin
                  data_in.alu_op = ALU_SLL;
                  if (ins[31:26] != 6'd0) data_in.cls = CLS_ILLEGAL;
               end
               default: begin
                  if (ins[31:26] == 6'd0) data_in.alu_op = ALU_SRL;
                  else if (ins[31:26] == 6'h10) data_in.alu_op = ALU_SRA;
                  else data_in.cls = CLS_ILLEGAL;
               end
            endcase
         end
         7'h33: begin
            if (f7 == 7'd1) begin
               data_in.cls = f3[2] ? CLS_DIV : CLS_MUL;
            end else if (f7 == 7'h20) begin
               if (f3 == 3'd0) begin data_in.cls = CLS_ALU; data_in.alu_op = ALU_SUB; end
               else if (f3 == 3'd5) begin data_in.cls = CLS_ALU; data_in.alu_op = ALU_SRA; end
            end else if (f7 == 7'd0) begin
               data_in.cls = CLS_ALU;
               case (f3)
                  3'd0: data_in.alu_op = ALU_ADD;
                  3'd1: data_in.alu_op = ALU_SLL;
                  3'd2: data_in.alu_op = ALU_SLT;
                  3'd3: data_in.alu_op = ALU_SLTU;
                  3'd4: data_in.alu_op = ALU_XOR;
                  3'd5: data_in.alu_op = ALU_SRL;
                  3'd6: data_in.alu_op = ALU_OR;
                  default: data_in.alu_op = ALU_AND;
               endcase
            end
         end
         7'h0F: if (f3 <= 3'd1) data_in.cls = CLS_NOP;
         7'h73: begin
            if (f3 == 3'd0) begin
               if (ins == 32'h0000_0073) data_in.cls = CLS_ECALL;
               else if (ins == 32'h3020_0073) data_in.cls = CLS_MRET;
               else if (ins == 32'h0010_0073) data_in.cls = CLS_EBREAK;
            end else if (f3 <= 3'd3) begin
               data_in.cls = CLS_CSR;
            end
         end
         default: data_in.cls = CLS_ILLEGAL;
      endcase
   end

   assign req_ready = !valid_ff || dec_ready;
   assign valid_in  = req_valid || (valid_ff && !dec_ready);

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
      if (req_valid && req_ready) data_ff <= data_in;
   end

   assign dec_valid = valid_ff;
   assign dec_data  = data_ff;

endmodule

[rtl/rv32ex_divider.sv]
// Radix-2 restoring divider for DIV/DIVU/REM/REMU, one quotient bit a cycle.
module rv32ex_divider import rv32ex_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [2:0]  f3,
   input  logic [31:0] a,
   input  logic [31:0] b,
   output logic        done,
   output logic [31:0] result
);

   logic        busy_ff, busy_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [31:0] quo_ff, quo_in, rem_ff, rem_in, dvs_ff, dvs_in;
   logic        negq_ff, negq_in, negr_ff, negr_in, zero_ff, zero_in, rems_ff, rems_in;
   logic [31:0] dvd_ff, dvd_in;
   logic [32:0] trial;

   always_comb begin
      logic sgn, na, nb;
      sgn = !f3[0];
      na  = sgn && a[31];
      nb  = sgn && b[31];
      busy_in = busy_ff; cnt_in = cnt_ff; quo_in = quo_ff; rem_in = rem_ff;
      dvs_in = dvs_ff; negq_in = negq_ff; negr_in = negr_ff; zero_in = zero_ff;
      rems_in = rems_ff; dvd_in = dvd_ff;
      trial = {rem_ff, quo_ff[31]} - {1'b0, dvs_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 6'd32;
         quo_in  = na ? 32'd0 - a : a;
         dvs_in  = nb ? 32'd0 - b : b;
         rem_in  = '0;
         negq_in = na ^ nb;
         negr_in = na;
         zero_in = (b == 32'd0);
         rems_in = f3[1];
         dvd_in  = a;
      end else if (busy_ff) begin
         if (!trial[32]) begin
            rem_in = trial[31:0];
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = {rem_ff[30:0], quo_ff[31]};
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in; rem_ff <= rem_in; dvs_ff <= dvs_in;
      negq_ff <= negq_in; negr_ff <= negr_in; zero_ff <= zero_in;
      rems_ff <= rems_in; dvd_ff <= dvd_in;
   end

   // high in the last iteration; the result registers settle at that edge
   assign done = busy_ff && cnt_ff == 6'd1;

   always_comb begin
      if (rems_ff)      result = zero_ff ? dvd_ff : (negr_ff ? 32'd0 - rem_ff : rem_ff);
      else if (zero_ff) result = 32'hFFFF_FFFF;
      else              result = negq_ff ? 32'd0 - quo_ff : quo_ff;
   end

endmodule

[rtl/rv32ex_execute.sv]
// Back end: executes decoded operations, owns the machine CSRs and the result register.
module rv32ex_execute import rv32ex_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    dec_valid,
   output logic    dec_ready,
   input  dec_type dec_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_MUL  = 2'd1;
   localparam logic [1:0] S_DIV  = 2'd2;
   localparam logic [1:0] S_WAIT = 2'd3;

   logic [1:0]  state_ff, state_in;
   logic        out_valid_ff, out_valid_in;
   rsp_type     out_ff, out_in;
   logic [31:0] mstatus_ff, mstatus_in, mtvec_ff, mtvec_in, mscratch_ff, mscratch_in;
   logic [31:0] mepc_ff, mepc_in, mcause_ff, mcause_in;
   logic [63:0] prod_ff;
   logic        div_start, div_done;
   logic [31:0] div_result;
   logic        out_free, take;
   rsp_type     res;
   logic [31:0] md_val;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign dec_ready = (state_ff == S_MUL || state_ff == S_WAIT) && out_free;
   assign take      = dec_valid && dec_ready;
   assign div_start = dec_valid && state_ff == S_IDLE && dec_data.cls == CLS_DIV;

   rv32ex_divider u_div (
      .clock (clock), .reset (reset), .start (div_start), .f3 (dec_data.f3),
      .a (dec_data.a), .b (dec_data.b), .done (div_done), .result (div_result)
   );

   always_comb begin
      unique case (state_ff)
         S_IDLE: begin
            if (!dec_valid)                 state_in = S_IDLE;
            else if (dec_data.cls == CLS_MUL) state_in = S_MUL;
            else if (dec_data.cls == CLS_DIV) state_in = S_DIV;
            else                            state_in = S_WAIT;
         end
         S_DIV:   state_in = div_done ? S_WAIT : S_DIV;
         default: state_in = take ? S_IDLE : state_ff;
      endcase
   end

   // Unsigned 32x32 product registered; signed variants corrected afterwards
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE) prod_ff <= {32'd0, dec_data.a} * {32'd0, dec_data.b};
   end

   always_comb begin
      logic [31:0] hu;
      hu = prod_ff[63:32];
      case (dec_data.f3[1:0])
         2'd0: md_val = prod_ff[31:0];
         2'd1: md_val = hu - (dec_data.a[31] ? dec_data.b : 32'd0)
                           - (dec_data.b[31] ? dec_data.a : 32'd0);
         2'd2: md_val = hu - (dec_data.a[31] ? dec_data.b : 32'd0);
         default: md_val = hu;
      endcase
   end

   always_comb begin
      logic [31:0] a, b, opb, alu, old, csr_new, pc4;
      logic [11:0] csra;
      logic        wr, ill, tk;
      logic [4:0]  sh;
      a   = dec_data.a;
      b   = dec_data.b;
      opb = dec_data.use_imm ? dec_data.imm : b;
      sh  = opb[4:0];
      pc4 = dec_data.pc + 32'd4;
      mstatus_in = mstatus_ff; mtvec_in = mtvec_ff; mscratch_in = mscratch_ff;
      mepc_in = mepc_ff; mcause_in = mcause_ff;
      case (dec_data.alu_op)
         ALU_SUB:  alu = a - opb;
         ALU_SLL:  alu = a << sh;
         ALU_SLT:  alu = {31'd0, $signed(a) < $signed(opb)};
         ALU_SLTU: alu = {31'd0, a < opb};
         ALU_XOR:  alu = a ^ opb;
         ALU_SRL:  alu = a >> sh;
         ALU_SRA:  alu = 32'($signed(a) >>> sh);
         ALU_OR:   alu = a | opb;
         ALU_AND:  alu = a & opb;
         default:  alu = a + opb;
      endcase
      csra = dec_data.instr[31:20];
      case (csra)
         CSR_MSTATUS:  old = mstatus_ff;
         CSR_MTVEC:    old = mtvec_ff;
         CSR_MSCRATCH: old = mscratch_ff;
         CSR_MEPC:     old = mepc_ff;
         CSR_MCAUSE:   old = mcause_ff;
         default:      old = '0;
      endcase
      case (dec_data.f3[1:0])
         2'd1:    csr_new = a;
         2'd2:    csr_new = old | a;
         default: csr_new = old & ~a;
      endcase
      res = '0;
      res.rd_index = dec_data.rd;
      res.next_pc  = pc4;
      wr  = 1'b0;
      ill = 1'b0;
      tk  = 1'b0;
      case (dec_data.cls)
         CLS_LUI:   begin wr = 1'b1; res.rd_value = dec_data.imm; end
         CLS_AUIPC: begin wr = 1'b1; res.rd_value = dec_data.pc + dec_data.imm; end
         CLS_JAL: begin
            wr = 1'b1; res.rd_value = pc4; res.next_pc = dec_data.pc + dec_data.imm;
         end
         CLS_JALR: begin
            wr = 1'b1; res.rd_value = pc4;
            res.next_pc = (a + dec_data.imm) & ~32'd1;
         end
         CLS_BRANCH: begin
            case (dec_data.f3)
               3'd0:    tk = a == b;
               3'd1:    tk = a != b;
               3'd4:    tk = $signed(a) < $signed(b);
               3'd5:    tk = !($signed(a) < $signed(b));
               3'd6:    tk = a < b;
               default: tk = a >= b;
            endcase
            if (tk) res.next_pc = dec_data.pc + dec_data.imm;
         end
         CLS_LOAD: begin
            res.mem_kind  = dec_data.f3[2] ? MEM_LOADU : MEM_LOADS;
            res.mem_bytes = 3'(3'd1 << dec_data.f3[1:0]);
            res.mem_addr  = a + dec_data.imm;
         end
         CLS_STORE: begin
            res.mem_kind   = MEM_STORE;
            res.mem_bytes  = 3'(3'd1 << dec_data.f3[1:0]);
            res.mem_addr   = a + dec_data.imm;
            res.store_data = b;
         end
         CLS_ALU: begin wr = 1'b1; res.rd_value = alu; end
         CLS_MUL: begin wr = 1'b1; res.rd_value = md_val; end
         CLS_DIV: begin wr = 1'b1; res.rd_value = div_result; end
         CLS_NOP: ;
         CLS_ECALL: begin
            res.next_pc = mtvec_ff;
            if (take) begin mepc_in = dec_data.pc; mcause_in = CAUSE_ECALL_M; end
         end
         CLS_MRET: begin
            res.next_pc = mepc_ff;
            if (take) mstatus_in = mstatus_ff & ~MSTATUS_MPP_MASK;
         end
         CLS_EBREAK: begin res.status = ST_EBREAK; res.next_pc = dec_data.pc; end
         CLS_CSR: begin
            wr = 1'b1; res.rd_value = old;
            if (take) begin
               case (csra)
                  CSR_MSTATUS:  mstatus_in  = csr_new;
                  CSR_MTVEC:    mtvec_in    = csr_new;
                  CSR_MSCRATCH: mscratch_in = csr_new;
                  CSR_MEPC:     mepc_in     = csr_new;
                  CSR_MCAUSE:   mcause_in   = csr_new;
                  default: ;
               endcase
            end
         end
         default: ill = 1'b1;
      endcase
      if (ill) begin
         res = '0;
         res.rd_index = dec_data.rd;
         res.next_pc  = dec_data.pc;
         res.status   = ST_ILLEGAL;
      end
      if (!wr || dec_data.rd == 5'd0) begin
         res.rd_write = 1'b0; res.rd_value = '0;
      end else begin
         res.rd_write = 1'b1;
      end
   end

   assign out_valid_in = take || (out_valid_ff && !rsp_ready);
   assign out_in       = take ? res : out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
         mstatus_ff   <= '0;
         mtvec_ff     <= '0;
         mscratch_ff  <= '0;
         mepc_ff      <= '0;
         mcause_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         mstatus_ff   <= mstatus_in;
         mtvec_ff     <= mtvec_in;
         mscratch_ff  <= mscratch_in;
         mepc_ff      <= mepc_in;
         mcause_ff    <= mcause_in;
      end
      out_ff <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   a_take_from_queue: assert property (@(posedge clock) disable iff (reset)
      take |-> dec_valid) else $error("took with empty queue");
   a_div_state: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> dec_valid && dec_data.cls == CLS_DIV)
      else $error("divide state without divide");
   a_rsp_x0: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.rd_index == 5'd0 |-> !rsp_data.rd_write)
      else $error("write to x0");
   a_ill_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_ILLEGAL |-> rsp_data.mem_kind == MEM_NONE)
      else $error("illegal with memory request");

endmodule

[rtl/rv32im_instruction_execute_unit.sv]
// RV32IM execute unit top level: decode front end, queue register, execute back end.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid / req_ready | req_data (req_type)
//   rsp     | out       | rsp_valid / rsp_ready | rsp_data (rsp_type)
//
// An instruction sits in the decode register while execute classifies it in S_IDLE;
// execute then takes it in S_WAIT and registers the result, which drives rsp_valid.
// The decode register refills only when empty or as execute takes the one it holds.
// MUL goes via S_MUL (product registered in S_IDLE), DIV via S_DIV for 32 quotient bits.
// Reset is synchronous and clears all control state and the five CSRs.
// Either side may stall; the decode register holds one instruction while execute is busy.
module rv32im_instruction_execute_unit import rv32ex_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic    dec_valid, dec_ready;
   dec_type dec_data;

   rv32ex_decode u_decode (
      .clock (clock), .reset (reset),
      .req_valid (req_valid), .req_ready (req_ready), .req_data (req_data),
      .dec_valid (dec_valid), .dec_ready (dec_ready), .dec_data (dec_data)
   );

   rv32ex_execute u_execute (
      .clock (clock), .reset (reset),
      .dec_valid (dec_valid), .dec_ready (dec_ready), .dec_data (dec_data),
      .rsp_valid (rsp_valid), .rsp_ready (rsp_ready), .rsp_data (rsp_data)
   );

endmodule

[dv/tb_rv32im_instruction_execute_unit.sv]
// Self-checking testbench for the RV32IM execute unit: directed and random instruction streams.
`timescale 1ns / 1ps

module tb_rv32im_instruction_execute_unit;
   import rv32ex_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int N_RANDOM    = 1600;

   localparam logic [6:0] OP_LUI    = 7'h37;
   localparam logic [6:0] OP_AUIPC  = 7'h17;
   localparam logic [6:0] OP_JAL    = 7'h6F;
   localparam logic [6:0] OP_JALR   = 7'h67;
   localparam logic [6:0] OP_BRANCH = 7'h63;
   localparam logic [6:0] OP_LOAD   = 7'h03;
   localparam logic [6:0] OP_STORE  = 7'h23;
   localparam logic [6:0] OP_IMM    = 7'h13;
   localparam logic [6:0] OP_REG    = 7'h33;
   localparam logic [6:0] OP_FENCE  = 7'h0F;
   localparam logic [6:0] OP_SYSTEM = 7'h73;
   localparam logic [31:0] INSN_ECALL  = 32'h0000_0073;
   localparam logic [31:0] INSN_EBREAK = 32'h0010_0073;
   localparam logic [31:0] INSN_MRET   = 32'h3020_0073;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   rv32im_instruction_execute_unit DUT (.*);

   always #6 clock = ~clock;

   // architectural CSR copy held by the predictor
   logic [31:0] m_status, m_tvec, m_scratch, m_epc, m_cause;

   req_type instr_queue[$];
   rsp_type result_queue[$];
   int errors = 0, cycles = 0, results_seen = 0, n_accepted = 0;
   bit stim_done = 0;
   bit hold_off_req = 0;   // receiver long stall request
   bit drain_req = 0;      // sender pause until all results are back

   function automatic logic [31:0] pred_csr_get(logic [11:0] a);
      case (a)
         CSR_MSTATUS:  return m_status;
         CSR_MTVEC:    return m_tvec;
         CSR_MSCRATCH: return m_scratch;
         CSR_MEPC:     return m_epc;
         CSR_MCAUSE:   return m_cause;
         default:      return '0;
      endcase
   endfunction

   task automatic pred_csr_put(logic [11:0] a, logic [31:0] v);
      case (a)
         CSR_MSTATUS:  m_status = v;
         CSR_MTVEC:    m_tvec = v;
         CSR_MSCRATCH: m_scratch = v;
         CSR_MEPC:     m_epc = v;
         CSR_MCAUSE:   m_cause = v;
         default: ;
      endcase
   endtask

   function automatic logic [31:0] muldiv(logic [2:0] f3, logic [31:0] a, logic [31:0] b);
      logic signed [63:0] ss, su;
      logic [63:0] uu;
      logic [31:0] sq, sr;
      ss = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
      su = $signed({{32{a[31]}}, a}) * $signed({32'b0, b});
      uu = {32'b0, a} * {32'b0, b};
      sq = '0;
      sr = '0;
      // signed quotient and remainder worked out apart from the unsigned selects below
      if (b != 32'd0) begin
         sq = $signed(a) / $signed(b);
         sr = $signed(a) % $signed(b);
      end
      case (f3)
         3'd0: return uu[31:0];
         3'd1: return ss[63:32];
         3'd2: return su[63:32];
         3'd3: return uu[63:32];
         3'd4: return (b == 0) ? 32'hFFFF_FFFF :
                      (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) ? a : sq;
         3'd5: return (b == 0) ? 32'hFFFF_FFFF : a / b;
         3'd6: return (b == 0) ? a :
                      (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) ? 32'd0 : sr;
         default: return (b == 0) ? a : a % b;
      endcase
   endfunction

   task automatic execute_instr(input req_type q, output rsp_type r);
      logic [31:0] ins, pc, a, b, imm_i, imm_s, imm_b, imm_u, imm_j, v, old;
      logic [6:0]  op, f7;
      logic [2:0]  f3;
      logic [5:0]  f6;
      logic        wr, ill, take;
      ins = q.instr; pc = q.pc; a = q.rs1_value; b = q.rs2_value;
      op = ins[6:0]; f3 = ins[14:12]; f7 = ins[31:25]; f6 = ins[31:26];
      imm_i = {{20{ins[31]}}, ins[31:20]};
      imm_s = {{20{ins[31]}}, ins[31:25], ins[11:7]};
      imm_b = {{20{ins[31]}}, ins[7], ins[30:25], ins[11:8], 1'b0};
      imm_u = {ins[31:12], 12'b0};
      imm_j = {{12{ins[31]}}, ins[19:12], ins[20], ins[30:21], 1'b0};
      r = '0;
      r.rd_index = ins[11:7];
      r.next_pc = pc + 4;
      r.mem_kind = MEM_NONE;
      r.status = ST_OK;
      wr = 0; ill = 0; v = 0; take = 0;
      case (op)
         OP_LUI:   begin wr = 1; v = imm_u; end
         OP_AUIPC: begin wr = 1; v = pc + imm_u; end
         OP_JAL:   begin wr = 1; v = pc + 4; r.next_pc = pc + imm_j; end
         OP_JALR: begin
            if (f3 != 0) ill = 1;
            else begin wr = 1; v = pc + 4; r.next_pc = (a + imm_i) & ~32'd1; end
         end
         OP_BRANCH: begin
            case (f3)
               3'd0: take = a == b;
               3'd1: take = a != b;
               3'd4: take = $signed(a) < $signed(b);
               3'd5: take = $signed(a) >= $signed(b);
               3'd6: take = a < b;
               3'd7: take = a >= b;
               default: ill = 1;
            endcase
            if (take) r.next_pc = pc + imm_b;
         end
         OP_LOAD: begin
            case (f3)
               3'd0: begin r.mem_kind = MEM_LOADS; r.mem_bytes = 3'd1; end
               3'd1: begin r.mem_kind = MEM_LOADS; r.mem_bytes = 3'd2; end
               3'd2: begin r.mem_kind = MEM_LOADS; r.mem_bytes = 3'd4; end
               3'd4: begin r.mem_kind = MEM_LOADU; r.mem_bytes = 3'd1; end
               3'd5: begin r.mem_kind = MEM_LOADU; r.mem_bytes = 3'd2; end
               default: ill = 1;
            endcase
            r.mem_addr = a + imm_i;
         end
         OP_STORE: begin
            if (f3 > 2) ill = 1;
            else begin
               r.mem_kind = MEM_STORE; r.mem_bytes = 3'd1 << f3;
               r.mem_addr = a + imm_s; r.store_data = b;
            end
         end
         OP_IMM: begin
            wr = 1;
            case (f3)
               3'd0: v = a + imm_i;
               3'd2: v = ($signed(a) < $signed(imm_i)) ? 32'd1 : 32'd0;
               3'd3: v = (a < imm_i) ? 32'd1 : 32'd0;
               3'd4: v = a ^ imm_i;
               3'd6: v = a | imm_i;
               3'd7: v = a & imm_i;
               3'd1: if (f6 == 0) v = a << imm_i[4:0]; else ill = 1;
               default: begin
                  if (f6 == 0) v = a >> imm_i[4:0];
                  else if (f6 == 6'h10) v = $signed(a) >>> imm_i[4:0];
                  else ill = 1;
               end
            endcase
         end
         OP_REG: begin
            wr = 1;
            if (f7 == 7'h01) v = muldiv(f3, a, b);
            else if (f7 == 7'h20) begin
               if (f3 == 0) v = a - b;
               else if (f3 == 5) v = $signed(a) >>> b[4:0];
               else ill = 1;
            end else if (f7 != 0) ill = 1;
            else case (f3)
               3'd0: v = a + b;
               3'd1: v = a << b[4:0];
               3'd2: v = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
               3'd3: v = (a < b) ? 32'd1 : 32'd0;
               3'd4: v = a ^ b;
               3'd5: v = a >> b[4:0];
               3'd6: v = a | b;
               default: v = a & b;
            endcase
         end
         OP_FENCE: if (f3 > 1) ill = 1;
         OP_SYSTEM: begin
            if (f3 == 0) begin
               if (ins == INSN_ECALL) begin
                  m_epc = pc; m_cause = CAUSE_ECALL_M; r.next_pc = m_tvec;
               end else if (ins == INSN_MRET) begin
                  r.next_pc = m_epc; m_status &= ~MSTATUS_MPP_MASK;
               end else if (ins == INSN_EBREAK) begin
                  r.status = ST_EBREAK; r.next_pc = pc;
               end else ill = 1;
            end else if (f3 <= 3) begin
               old = pred_csr_get(ins[31:20]);
               if (f3 == 1) pred_csr_put(ins[31:20], a);
               else if (f3 == 2) pred_csr_put(ins[31:20], old | a);
               else pred_csr_put(ins[31:20], old & ~a);
               wr = 1; v = old;
            end else ill = 1;
         end
         default: ill = 1;
      endcase
      if (ill) begin
         wr = 0; r.next_pc = pc; r.mem_kind = MEM_NONE; r.mem_bytes = '0;
         r.mem_addr = 0; r.store_data = 0; r.status = ST_ILLEGAL;
      end
      if (r.mem_kind == MEM_NONE) r.mem_addr = 0;
      if (!wr || r.rd_index == 0) begin wr = 0; v = 0; end
      r.rd_write = wr;
      r.rd_value = v;
   endtask

   function automatic logic [31:0] rand_operand();
      case ($urandom_range(0, 7))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         2: return 32'h8000_0000;
         3: return 32'h7FFF_FFFF;
         4: return $urandom_range(0, 40);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [11:0] rand_csr();
      case ($urandom_range(0, 5))
         0: return CSR_MSTATUS;
         1: return CSR_MTVEC;
         2: return CSR_MSCRATCH;
         3: return CSR_MEPC;
         4: return CSR_MCAUSE;
         default: return 12'($urandom);
      endcase
   endfunction

   // mostly well-formed encodings with random fields, some raw noise
   function automatic logic [31:0] rand_instr();
      logic [31:0] w;
      logic [6:0]  ops [11];
      ops = '{OP_LUI, OP_AUIPC, OP_JAL, OP_JALR, OP_BRANCH, OP_LOAD, OP_STORE,
              OP_IMM, OP_REG, OP_FENCE, OP_SYSTEM};
      w = $urandom;
      if ($urandom_range(0, 19) == 0) return w;
      w[6:0] = ops[$urandom_range(0, 10)];
      case (w[6:0])
         OP_REG: begin
            case ($urandom_range(0, 5))
               0, 1: w[31:25] = 7'h01;
               2:    w[31:25] = 7'h20;
               3, 4: w[31:25] = 7'h00;
               default: ;
            endcase
         end
         OP_IMM: if ($urandom_range(0, 3) != 0) w[31:26] = $urandom_range(0, 1) ? 6'h10 : 6'h00;
         OP_SYSTEM: begin
            case ($urandom_range(0, 7))
               0: w = INSN_ECALL;
               1: w = INSN_MRET;
               2: w = INSN_EBREAK;
               3: ;
               default: begin
                  w[14:12] = 3'($urandom_range(1, 3));
                  w[31:20] = rand_csr();
               end
            endcase
         end
         default: ;
      endcase
      return w;
   endfunction

   task automatic queue_instr(logic [31:0] w, logic [31:0] a, logic [31:0] b);
      req_type q;
      q.instr = w; q.pc = $urandom; q.rs1_value = a; q.rs2_value = b;
      instr_queue.push_back(q);
   endtask

   // driver
   int req_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            rsp_type e;
            execute_instr(req_data, e);
            result_queue.push_back(e);
            n_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (drain_req && result_queue.size() > 0) begin
               req_valid <= 1'b0;
            end else if (instr_queue.size() > 0) begin
               req_data <= instr_queue.pop_front();
               req_valid <= 1'b1;
               req_gap = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 6) : 0;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   int rsp_gap = 0, hold_count = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (result_queue.size() == 0) begin
               errors++;
               $display("%0t: unexpected transaction, actual %p", $realtime, rsp_data);
            end else begin
               rsp_type e;
               e = result_queue.pop_front();
               if (rsp_data !== e) begin
                  errors++;
                  $display("%0t: result differs\n  expected %p\n  actual   %p",
                           $realtime, e, rsp_data);
               end
            end
         end
         if (hold_off_req && hold_count == 0) hold_count = 300;
         if (hold_count > 0) begin
            hold_count--;
            rsp_ready <= 1'b0;
         end else if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (!stim_done && $urandom_range(0, 2) == 0) rsp_gap = $urandom_range(0, 6);
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("rv32im_instruction_execute_unit: mismatch");
         $finish;
      end
   end

   initial begin
      m_status = 0; m_tvec = 0; m_scratch = 0; m_epc = 0; m_cause = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, each class, divide corners, CSR and trap flow
      queue_instr({20'hFFFFF, 5'd1, OP_LUI}, 0, 0);
      queue_instr({20'h80000, 5'd31, OP_AUIPC}, 0, 0);
      queue_instr({12'h305, 5'd2, 3'd1, 5'd3, OP_SYSTEM}, 32'h0000_1000, 0);
      queue_instr({12'h300, 5'd2, 3'd2, 5'd3, OP_SYSTEM}, 32'hFFFF_FFFF, 0);
      queue_instr(INSN_ECALL, 0, 0);
      queue_instr({12'h342, 5'd2, 3'd3, 5'd4, OP_SYSTEM}, 32'h0000_0001, 0);
      queue_instr({12'h341, 5'd2, 3'd2, 5'd5, OP_SYSTEM}, 0, 0);
      queue_instr(INSN_MRET, 0, 0);
      queue_instr({12'h300, 5'd2, 3'd2, 5'd6, OP_SYSTEM}, 0, 0);
      queue_instr({12'h7C0, 5'd2, 3'd1, 5'd6, OP_SYSTEM}, 32'h1234, 0);
      queue_instr(INSN_EBREAK, 0, 0);
      queue_instr({7'h01, 5'd2, 5'd1, 3'd4, 5'd7, OP_REG}, 32'h8000_0000, 32'hFFFF_FFFF);
      queue_instr({7'h01, 5'd2, 5'd1, 3'd6, 5'd7, OP_REG}, 32'h8000_0000, 32'hFFFF_FFFF);
      queue_instr({7'h01, 5'd2, 5'd1, 3'd5, 5'd7, OP_REG}, 32'h1234_5678, 0);
      queue_instr({7'h01, 5'd2, 5'd1, 3'd7, 5'd7, OP_REG}, 32'h1234_5678, 0);
      queue_instr({7'h01, 5'd2, 5'd1, 3'd1, 5'd7, OP_REG}, 32'h8000_0000, 32'h8000_0000);
      queue_instr({7'h20, 5'd2, 5'd1, 3'd5, 5'd8, OP_REG}, 32'h8000_0000, 32'hFFFF_FFFF);
      queue_instr({6'h10, 6'd31, 5'd1, 3'd5, 5'd8, OP_IMM}, 32'h8000_0000, 0);
      queue_instr({12'hFFF, 5'd1, 3'd0, 5'd9, OP_JALR}, 32'h0000_0010, 0);
      queue_instr({20'hFFFFF, 5'd10, OP_JAL}, 0, 0);
      queue_instr({7'h7F, 5'd2, 5'd1, 3'd4, 5'h1F, OP_BRANCH}, 32'hFFFF_FFFF, 1);
      queue_instr({12'h800, 5'd1, 3'd5, 5'd11, OP_LOAD}, 32'hFFFF_FFFF, 0);
      queue_instr({12'h000, 5'd1, 3'd3, 5'd11, OP_LOAD}, 0, 0);
      queue_instr({7'h7F, 5'd2, 5'd1, 3'd2, 5'h1F, OP_STORE}, 0, 32'hFFFF_FFFF);
      queue_instr({12'h001, 5'd0, 3'd1, 5'd0, OP_FENCE}, 0, 0);

      for (int i = 0; i < N_RANDOM; i++) begin
         queue_instr(rand_instr(), rand_operand(), rand_operand());
         if (i == 500) begin
            // receiver stalls for a long stretch while the sender keeps offering
            wait (instr_queue.size() == 0);
            hold_off_req = 1;
            wait (hold_count > 0);
            hold_off_req = 0;
         end
         if (i == 1000) begin
            wait (instr_queue.size() == 0);
            drain_req = 1;
            wait (result_queue.size() == 0);
            drain_req = 0;
         end
      end

      wait (instr_queue.size() == 0 && !req_valid);
      stim_done = 1;
      wait (result_queue.size() == 0);
      repeat (60) @(posedge clock);
      $display("accepted %0d instructions covering every opcode class, M-extension corners,",
               n_accepted);
      $display("CSR access, traps and illegal encodings; %0d results checked", results_seen);
      if (errors == 0 && result_queue.size() == 0) begin
         $display("rv32im_instruction_execute_unit: match");
      end else begin
         $display("rv32im_instruction_execute_unit: mismatch");
      end
      $finish;
   end

endmodule
